// ===== hdl/prqs_pkg.sv =====
// Package for the priority ready-queue scheduler: opcodes, priorities, widths.
// No dependencies.
`timescale 1ns / 1ps
package prqs_pkg;
    localparam int MAX_THREADS_DEF = 16;
    localparam int TICK_BITS_DEF   = 16;
    localparam int IN_TICK_W       = 16;

    localparam logic [1:0] OP_ACTIVATE = 2'd0;
    localparam logic [1:0] OP_SLEEP    = 2'd1;
    localparam logic [1:0] OP_TICK     = 2'd2;

    localparam logic [1:0] PRIO_IDLE   = 2'd0;
    localparam logic [1:0] PRIO_NORMAL = 2'd2;

    localparam logic [3:0] IDLE_ID = 4'd1;

    // Datapath command from the controller
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,       // latch input item, set priority on activate
        CMD_PUSH_SEL,   // enqueue activated thread
        CMD_PREEMPT,    // check preemption against the work thread
        CMD_PUSH_CUR,   // enqueue current thread by its priority
        CMD_PARK,       // park current thread as sleeper
        CMD_DISPATCH,   // pop highest queue into current
        CMD_TICK_STEP,  // count one sleeper down
        CMD_TICK_START  // rewind the sleeper scan
    } prqs_cmd_t;

    typedef struct packed {
        logic outranks;   // work thread outranks current
        logic woke;       // tick step woke its thread
        logic last_idx;   // tick index is at the last thread
    } prqs_stat_t;
endpackage

// ===== hdl/priority_ready_queue_scheduler_unit.sv =====
// Top level of the three-level priority ready-queue scheduler.
// Depends on prqs_pkg, prqs_ctrl, prqs_datapath.
//
//  channel | dir | tdata fields (low bit first)                           | tuser
//  s_      | in  | opcode[1:0] thread_sel[5:2] prio_level[7:6]
//          |     | sleep_ticks[23:8] wait_forever[24], 32 bits            | -
//  m_      | out | running_thread[3:0] switched[4] status[5], 8 bits      | -
//
// One item at a time. An activate queues the thread and, when it preempts,
// re-queues the current thread and dispatches; a sleep parks or re-queues the
// current thread, then dispatches; a rejected item goes straight to its result.
// A tick scans sleep counters one thread per cycle, pausing for each woken thread.
// Reset is synchronous; the result holds until taken and stalls the input.
`timescale 1ns / 1ps
module priority_ready_queue_scheduler_unit #(
    parameter int MAX_THREADS = prqs_pkg::MAX_THREADS_DEF,
    parameter int TICK_BITS   = prqs_pkg::TICK_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // opcode, thread_sel, prio_level, sleep_ticks, wait_forever
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // running_thread, switched, status
);
    prqs_pkg::prqs_cmd_t  cmd;
    prqs_pkg::prqs_stat_t stat;
    logic       clr_switch;
    logic       status;
    logic [3:0] cur_id;
    logic       switched;

    prqs_ctrl #(.MAX_THREADS(MAX_THREADS)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_op(s_tdata[1:0]), .in_sel(s_tdata[5:2]),
        .in_forever(s_tdata[24]), .in_ticks(s_tdata[23:8]),
        .stat(stat), .cmd(cmd), .clr_switch(clr_switch),
        .out_valid(m_tvalid), .out_ready(m_tready), .status(status)
    );

    prqs_datapath #(.MAX_THREADS(MAX_THREADS), .TICK_BITS(TICK_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .clr_switch(clr_switch),
        .in_sel(s_tdata[5:2]), .in_prio(s_tdata[7:6]), .in_ticks(s_tdata[23:8]),
        .stat(stat), .cur_id(cur_id), .switched(switched)
    );

    assign m_tdata = {2'b00, status, switched, cur_id};
endmodule

// ===== hdl/prqs_datapath.sv =====
// Datapath: ready queues, thread tables, current-thread register.
// Depends on prqs_pkg.
`timescale 1ns / 1ps
module prqs_datapath #(
    parameter int MAX_THREADS = prqs_pkg::MAX_THREADS_DEF,
    parameter int TICK_BITS   = prqs_pkg::TICK_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  prqs_pkg::prqs_cmd_t cmd,
    input  logic                clr_switch,
    input  logic [3:0]          in_sel,
    input  logic [1:0]          in_prio,
    input  logic [15:0]         in_ticks,
    output prqs_pkg::prqs_stat_t stat,
    output logic [3:0]          cur_id,
    output logic                switched
);
    localparam int IW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
    localparam int CW = $clog2(MAX_THREADS + 1);
    localparam logic [TICK_BITS-1:0] TICK_MAX = {TICK_BITS{1'b1}};

    logic [IW-1:0]        q_mem [3][MAX_THREADS];
    logic [IW-1:0]        head_reg [3];
    logic [CW-1:0]        count_reg [3];
    logic [IW-1:0]        cur_reg;
    logic [1:0]           prio_reg [MAX_THREADS];
    logic [TICK_BITS-1:0] cnt_reg [MAX_THREADS];
    logic [MAX_THREADS-1:0] sleep_reg;
    logic [IW-1:0]        work_reg;  // thread under consideration
    logic [IW-1:0]        tidx_reg;
    logic                 sw_reg;

    logic [1:0]    push_prio;
    logic [IW-1:0] push_id;
    logic          push_en;
    logic [1:0]    pk;
    logic [IW:0]   push_sum;
    logic [IW-1:0] push_pos;
    logic [IW-1:0] pop_id;
    logic [1:0]    pop_k;
    logic          pop_any;
    logic [IW-1:0] head_inc;
    logic [TICK_BITS-1:0] tick_sat;
    logic [TICK_BITS-1:0] dec;

    // Idle thread id at internal width
    localparam logic [IW-1:0] IDLE_IW = IW'(prqs_pkg::IDLE_ID);

    assign tick_sat = (TICK_BITS >= 16) ? TICK_BITS'(in_ticks) :
                      ((in_ticks > 16'(TICK_MAX)) ? TICK_MAX : TICK_BITS'(in_ticks));
    assign dec = cnt_reg[tidx_reg] - 1'b1;

    // Select push source and the tail slot, wrapping at the queue depth
    always_comb begin
        push_en   = 1'b0;
        push_prio = prio_reg[cur_reg];
        push_id   = cur_reg;
        if (cmd == prqs_pkg::CMD_PUSH_SEL) begin
            push_en = 1'b1; push_prio = prio_reg[work_reg]; push_id = work_reg;
        end else if (cmd == prqs_pkg::CMD_PUSH_CUR) begin
            push_en = 1'b1;
        end
        pk = push_prio - 2'd1;
        push_sum = (IW+1)'(head_reg[pk]) + (IW+1)'(count_reg[pk]);
        push_pos = (push_sum >= (IW+1)'(MAX_THREADS)) ?
                   IW'(push_sum - (IW+1)'(MAX_THREADS)) : IW'(push_sum);
    end

    // Highest non-empty queue
    always_comb begin
        pop_any = 1'b1; pop_k = 2'd2;
        if (count_reg[2] != '0) pop_k = 2'd2;
        else if (count_reg[1] != '0) pop_k = 2'd1;
        else if (count_reg[0] != '0) pop_k = 2'd0;
        else pop_any = 1'b0;
        pop_id = pop_any ? q_mem[pop_k][head_reg[pop_k]] : IDLE_IW;
    end

    // Advance the head, wrapping at the queue depth
    assign head_inc = (head_reg[pop_k] == IW'(MAX_THREADS - 1)) ? '0 :
                      head_reg[pop_k] + 1'b1;

    assign stat = prqs_pkg::prqs_stat_t'({
                      prio_reg[work_reg] > prio_reg[cur_reg],
                      sleep_reg[tidx_reg] && (cnt_reg[tidx_reg] == TICK_BITS'(1)),
                      tidx_reg == IW'(MAX_THREADS - 1)});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 3; k++) begin
                head_reg[k] <= '0; count_reg[k] <= '0;
            end
            for (int i = 0; i < MAX_THREADS; i++) begin
                prio_reg[i] <= prqs_pkg::PRIO_IDLE;
                cnt_reg[i]  <= '0;
            end
            prio_reg[0] <= prqs_pkg::PRIO_NORMAL;
            sleep_reg <= '0;
            cur_reg   <= '0;
            work_reg  <= '0;
            tidx_reg  <= '0;
            sw_reg    <= 1'b0;
        end else begin
            if (clr_switch) sw_reg <= 1'b0;
            // Push into queue, drop when idle prio or full
            if (push_en && push_prio != prqs_pkg::PRIO_IDLE &&
                count_reg[pk] != CW'(MAX_THREADS)) begin
                q_mem[pk][push_pos] <= push_id;
                count_reg[pk] <= count_reg[pk] + 1'b1;
            end
            unique case (cmd)
                prqs_pkg::CMD_LOAD: begin
                    work_reg <= IW'(in_sel);
                    prio_reg[IW'(in_sel)] <= in_prio;
                end
                prqs_pkg::CMD_TICK_START: begin
                    tidx_reg <= '0;
                end
                prqs_pkg::CMD_PARK: begin
                    cnt_reg[cur_reg]   <= tick_sat;
                    sleep_reg[cur_reg] <= 1'b1;
                end
                prqs_pkg::CMD_DISPATCH: begin
                    if (pop_any) begin
                        head_reg[pop_k]  <= head_inc;
                        count_reg[pop_k] <= count_reg[pop_k] - 1'b1;
                    end
                    if (pop_id != cur_reg) sw_reg <= 1'b1;
                    cur_reg <= pop_id;
                end
                prqs_pkg::CMD_TICK_STEP: begin
                    if (sleep_reg[tidx_reg] && cnt_reg[tidx_reg] != '0) begin
                        cnt_reg[tidx_reg] <= dec;
                        if (dec == '0) sleep_reg[tidx_reg] <= 1'b0;
                    end
                    work_reg <= tidx_reg;
                    tidx_reg <= tidx_reg + 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign cur_id   = 4'(cur_reg);
    assign switched = sw_reg;
endmodule

// ===== hdl/prqs_ctrl.sv =====
// Controller FSM: sequences datapath commands per item, holds handshake.
// Depends on prqs_pkg.
`timescale 1ns / 1ps
module prqs_ctrl #(
    parameter int MAX_THREADS = prqs_pkg::MAX_THREADS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           in_op,
    input  logic [3:0]           in_sel,
    input  logic                 in_forever,
    input  logic [15:0]          in_ticks,
    input  prqs_pkg::prqs_stat_t stat,
    output prqs_pkg::prqs_cmd_t  cmd,
    output logic                 clr_switch,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 status
);
    typedef enum logic [2:0] {
        S_IDLE, S_PUSH_SEL, S_CHECK, S_PUSH_CUR, S_DISPATCH,
        S_TICK_CHECK, S_RESULT
    } state_t;

    state_t state_reg, state_next;
    logic   tick_reg, tick_next;
    logic   status_reg, status_next;
    logic   sel_ok;

    assign sel_ok = 32'(in_sel) < MAX_THREADS;

    always_comb begin
        state_next  = state_reg;
        tick_next   = tick_reg;
        status_next = status_reg;
        cmd         = prqs_pkg::CMD_NONE;
        clr_switch  = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    clr_switch  = 1'b1;
                    status_next = 1'b0;
                    tick_next   = 1'b0;
                    state_next  = S_RESULT;
                    case (in_op)
                        prqs_pkg::OP_ACTIVATE: begin
                            if (sel_ok) begin
                                cmd = prqs_pkg::CMD_LOAD; state_next = S_PUSH_SEL;
                            end else status_next = 1'b1;
                        end
                        prqs_pkg::OP_SLEEP: begin
                            if (in_forever) status_next = 1'b1;
                            else if (in_ticks == 16'd0) begin
                                cmd = prqs_pkg::CMD_PUSH_CUR; state_next = S_DISPATCH;
                            end else begin
                                cmd = prqs_pkg::CMD_PARK; state_next = S_DISPATCH;
                            end
                        end
                        prqs_pkg::OP_TICK: begin
                            cmd = prqs_pkg::CMD_TICK_START; tick_next = 1'b1;
                            state_next = S_TICK_CHECK;
                        end
                        default: status_next = 1'b1;
                    endcase
                end
            end
            S_PUSH_SEL: begin
                cmd = prqs_pkg::CMD_PUSH_SEL; state_next = S_CHECK;
            end
            S_CHECK: state_next = stat.outranks ? S_PUSH_CUR :
                                  (tick_reg ? S_TICK_CHECK : S_RESULT);
            S_PUSH_CUR: begin
                cmd = prqs_pkg::CMD_PUSH_CUR; state_next = S_DISPATCH;
            end
            S_DISPATCH: begin
                cmd = prqs_pkg::CMD_DISPATCH;
                state_next = tick_reg ? S_TICK_CHECK : S_RESULT;
            end
            S_TICK_CHECK: begin
                // Step one sleeper; a wake queues it, the last thread ends the scan
                cmd = prqs_pkg::CMD_TICK_STEP;
                if (stat.woke) begin
                    state_next = S_PUSH_SEL;
                    if (stat.last_idx) tick_next = 1'b0;
                end else begin
                    state_next = stat.last_idx ? S_RESULT : S_TICK_CHECK;
                end
            end
            S_RESULT: if (out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            tick_reg   <= 1'b0;
            status_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            tick_reg   <= tick_next;
            status_reg <= status_next;
        end
    end

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = state_reg == S_RESULT;
    assign status    = status_reg;
endmodule

// ===== sim/priority_ready_queue_scheduler_unit_test.sv =====
// Testbench for priority_ready_queue_scheduler_unit: directed and random scheduler items,
// results checked against a built-in scheduler predictor. Depends on prqs_pkg and the DUT.
`timescale 1ns / 1ps
module priority_ready_queue_scheduler_unit_test;
    localparam int NTHR = 16;
    localparam logic [15:0] TICK_SAT = 16'hFFFF;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic       status;
        logic       switched;
        logic [3:0] running_thread;
    } sched_res_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;

    priority_ready_queue_scheduler_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Scheduler shadow state; queue index 0 low, 1 normal, 2 high
    logic [3:0]  rq_slot [3][NTHR];
    int          rq_head [3];
    int          rq_cnt  [3];
    logic [3:0]  run_id;
    logic [1:0]  thr_prio [NTHR];
    logic [15:0] nap_cnt  [NTHR];
    logic        napping  [NTHR];
    logic        sw_flag;

    logic [31:0] pending_items[$];
    sched_res_t  expected_results[$];
    int          errors = 0;
    int          cycles = 0;
    bit          stim_done = 0;
    bit          in_taken = 0;

    function automatic void ready_push(logic [1:0] p, logic [3:0] id);
        int k;
        if (p == prqs_pkg::PRIO_IDLE) return;
        k = int'(p) - 1;
        if (rq_cnt[k] >= NTHR) return;
        rq_slot[k][(rq_head[k] + rq_cnt[k]) % NTHR] = id;
        rq_cnt[k]++;
    endfunction

    function automatic void pick_next();
        logic [3:0] id;
        id = prqs_pkg::IDLE_ID;
        for (int k = 2; k >= 0; k--) begin
            if (rq_cnt[k] > 0) begin
                id = rq_slot[k][rq_head[k]];
                rq_head[k] = (rq_head[k] + 1) % NTHR;
                rq_cnt[k]--;
                break;
            end
        end
        if (id != run_id) sw_flag = 1'b1;
        run_id = id;
    endfunction

    function automatic void maybe_preempt(logic [3:0] id);
        if (thr_prio[id] > thr_prio[run_id]) begin
            ready_push(thr_prio[run_id], run_id);
            pick_next();
        end
    endfunction

    function automatic sched_res_t schedule_item(logic [31:0] d);
        logic [1:0]  op;
        logic [3:0]  sel;
        logic [1:0]  pr;
        logic [15:0] tk;
        logic        fv;
        logic        st;
        op = d[1:0]; sel = d[5:2]; pr = d[7:6]; tk = d[23:8]; fv = d[24];
        st = 1'b0;
        sw_flag = 1'b0;
        if (op == prqs_pkg::OP_ACTIVATE) begin
            thr_prio[sel] = pr;
            ready_push(pr, sel);
            maybe_preempt(sel);
        end else if (op == prqs_pkg::OP_SLEEP) begin
            if (fv) st = 1'b1;
            else begin
                if (tk == 0) ready_push(thr_prio[run_id], run_id);
                else begin
                    nap_cnt[run_id] = (tk > TICK_SAT) ? TICK_SAT : tk;
                    napping[run_id] = 1'b1;
                end
                pick_next();
            end
        end else if (op == prqs_pkg::OP_TICK) begin
            for (int i = 0; i < NTHR; i++) begin
                if (napping[i] && nap_cnt[i] >= 1) begin
                    nap_cnt[i]--;
                    if (nap_cnt[i] == 0) begin
                        napping[i] = 1'b0;
                        ready_push(thr_prio[i], i[3:0]);
                        maybe_preempt(i[3:0]);
                    end
                end
            end
        end else begin
            st = 1'b1;
        end
        return '{running_thread: run_id, switched: sw_flag, status: st};
    endfunction

    function automatic logic [31:0] pack_item(logic [1:0] op, logic [3:0] sel, logic [1:0] pr,
                                              logic [15:0] tk, logic fv);
        return {7'd0, fv, tk, pr, sel, op};
    endfunction

    function automatic void add_item(logic [1:0] op, logic [3:0] sel, logic [1:0] pr,
                                     logic [15:0] tk, logic fv);
        pending_items = {pending_items, pack_item(op, sel, pr, tk, fv)};
    endfunction

    // Driver: bursts and gaps, item changes at the falling edge
    int burst_left = 0;
    int gap_left = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || in_taken) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    s_tdata <= pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    if (burst_left > 0) burst_left--;
                    else begin
                        burst_left = $urandom_range(0, 12);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                    if (stim_done == 0) stim_done = 1;
                end
            end
            // Receiver stall pattern: long open stretches, then random stalls
            m_tready <= ((cycles / 200) % 3 == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
        end
    end

    // Monitor: predict on input accept, compare results at the rising edge
    always @(posedge aclk) begin
        sched_res_t got, want;
        cycles <= cycles + 1;
        in_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready)
            expected_results = {expected_results, schedule_item(s_tdata)};
        if (aresetn && m_tvalid && m_tready) begin
            got = sched_res_t'(m_tdata[5:0]);
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (got.running_thread != want.running_thread) begin
                    $display("%0t: running_thread expected %0d actual %0d", $time,
                             want.running_thread, got.running_thread);
                    errors++;
                end
                if (got.switched != want.switched) begin
                    $display("%0t: switched expected %0d actual %0d", $time,
                             want.switched, got.switched);
                    errors++;
                end
                if (got.status != want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, got.status);
                    errors++;
                end
            end
        end
    end

    // Timeout watchdog
    always @(posedge aclk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        logic [1:0] op;
        int r;
        for (int k = 0; k < 3; k++) begin
            rq_head[k] = 0;
            rq_cnt[k] = 0;
            for (int j = 0; j < NTHR; j++) rq_slot[k][j] = '0;
        end
        for (int i = 0; i < NTHR; i++) begin
            thr_prio[i] = prqs_pkg::PRIO_IDLE;
            nap_cnt[i] = '0;
            napping[i] = 1'b0;
        end
        thr_prio[0] = prqs_pkg::PRIO_NORMAL;
        run_id = '0;

        // Directed: every opcode, priority extremes, yields, infinite sleep, bad opcode
        add_item(prqs_pkg::OP_ACTIVATE, 4'd5, 2'd3, 16'd0, 1'b0);
        add_item(prqs_pkg::OP_ACTIVATE, 4'd15, 2'd1, 16'hFFFF, 1'b1);
        add_item(prqs_pkg::OP_ACTIVATE, 4'd0, 2'd2, 16'd0, 1'b0);
        add_item(prqs_pkg::OP_ACTIVATE, 4'd7, 2'd0, 16'd0, 1'b0);
        add_item(prqs_pkg::OP_SLEEP, 4'd0, 2'd0, 16'd0, 1'b0);
        add_item(prqs_pkg::OP_SLEEP, 4'd0, 2'd0, 16'd2, 1'b0);
        add_item(prqs_pkg::OP_SLEEP, 4'd0, 2'd0, 16'd5, 1'b1);
        add_item(prqs_pkg::OP_SLEEP, 4'd0, 2'd0, 16'hFFFF, 1'b0);
        add_item(prqs_pkg::OP_TICK, 4'd0, 2'd0, 16'd0, 1'b0);
        add_item(prqs_pkg::OP_TICK, 4'd15, 2'd3, 16'hFFFF, 1'b1);
        add_item(OP_UNUSED, 4'd9, 2'd2, 16'd1, 1'b0);
        add_item(prqs_pkg::OP_SLEEP, 4'd0, 2'd0, 16'd1, 1'b0);
        add_item(prqs_pkg::OP_TICK, 4'd0, 2'd0, 16'd0, 1'b0);
        // Fill the high queue past full
        for (int i = 0; i < 18; i++)
            add_item(prqs_pkg::OP_ACTIVATE, i[3:0], 2'd3, 16'd0, 1'b0);

        // Random: mostly ticks and activations, short sleeps so sleepers wake
        for (int n = 0; n < 550; n++) begin
            r = $urandom_range(0, 99);
            if (r < 35) op = prqs_pkg::OP_ACTIVATE;
            else if (r < 60) op = prqs_pkg::OP_SLEEP;
            else if (r < 97) op = prqs_pkg::OP_TICK;
            else op = OP_UNUSED;
            add_item(op, 4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)),
                ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6)),
                ($urandom_range(0, 14) == 0));
        end

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        while (!(stim_done == 1 && !s_tvalid && expected_results.size() == 0))
            @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
hdl/prqs_pkg.sv
hdl/prqs_datapath.sv
hdl/prqs_ctrl.sv
hdl/priority_ready_queue_scheduler_unit.sv
sim/priority_ready_queue_scheduler_unit_test.sv
